// ----- rtl/core/afc_pkg.sv -----
// ----------------------------------------------------------------------------
// afc_pkg
// shared constants, types and helpers of the altitude filter chain
// ----------------------------------------------------------------------------
`default_nettype none

package afc_pkg;

    // altitude format and factor format
    localparam int FRACTION_BITS = 16;
    localparam int FACTOR_BITS   = 16;
    localparam int DRIFT_SHIFT   = 24 - FRACTION_BITS;

    localparam int ALT_W    = 32;
    localparam int FACTOR_W = 17;
    localparam int TEMP_W   = 16;
    localparam int DT_W     = 16;
    localparam int BAND_W   = 21;
    localparam int GAIN_W   = 18;

    // shared multiplier and accumulator widths
    localparam int OPA_W  = ALT_W + 1;
    localparam int OPB_W  = GAIN_W;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int PRE_W  = PROD_W + 1;
    localparam int SUM_W  = PRE_W - FACTOR_BITS;
    localparam int TOT_W  = SUM_W + 1;

    localparam logic [FACTOR_W-1:0] FACTOR_ONE = FACTOR_W'(2 ** FACTOR_BITS);
    localparam logic signed [PRE_W-1:0] ROUND_HALF = PRE_W'((2 ** FACTOR_BITS) / 2);
    localparam logic signed [PRE_W-1:0] DRIFT_HALF = PRE_W'((2 ** DRIFT_SHIFT) / 2);

    localparam longint GRAVITY_WIDE =
        ((64'd980665 << FRACTION_BITS) + 64'd50000) / 64'd100000;
    localparam logic signed [OPA_W-1:0] GRAVITY = OPA_W'(GRAVITY_WIDE);

    localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(32'sh7FFF_FFFF);
    localparam logic signed [TOT_W-1:0] SAT_LO = TOT_W'(32'sh8000_0000);

    // sequencer
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(13);

    // datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
    localparam logic [OP_W-1:0] OP_FAST   = 4'd1;
    localparam logic [OP_W-1:0] OP_SLOW   = 4'd2;
    localparam logic [OP_W-1:0] OP_DRIFT  = 4'd3;
    localparam logic [OP_W-1:0] OP_VEL    = 4'd4;
    localparam logic [OP_W-1:0] OP_INERT  = 4'd5;
    localparam logic [OP_W-1:0] OP_SMOOTH = 4'd6;
    localparam logic [OP_W-1:0] OP_BARO   = 4'd7;
    localparam logic [OP_W-1:0] OP_FUSED  = 4'd8;

    // register map
    localparam int APB_ADDR_W = 5;
    localparam int REG_W      = 3;
    localparam logic [REG_W-1:0] REG_FAST_SMOOTHING  = 3'd0;
    localparam logic [REG_W-1:0] REG_SLOW_SMOOTHING  = 3'd1;
    localparam logic [REG_W-1:0] REG_DEAD_BAND       = 3'd2;
    localparam logic [REG_W-1:0] REG_DRIFT_GAIN      = 3'd3;
    localparam logic [REG_W-1:0] REG_REFERENCE_TEMP  = 3'd4;
    localparam logic [REG_W-1:0] REG_BLEND_FACTOR    = 3'd5;
    localparam logic [REG_W-1:0] REG_ACCEL_SMOOTHING = 3'd6;
    localparam logic [REG_W-1:0] REG_REFERENCE_VALID = 3'd7;

    typedef struct packed {
        logic        [FACTOR_W-1:0] fast_smoothing;
        logic        [FACTOR_W-1:0] slow_smoothing;
        logic        [BAND_W-1:0]   dead_band;
        logic signed [GAIN_W-1:0]   drift_gain;
        logic signed [TEMP_W-1:0]   reference_temperature;
        logic        [FACTOR_W-1:0] blend_factor;
        logic        [FACTOR_W-1:0] accel_smoothing;
        logic                       reference_valid;
    } cfg_t;

    typedef struct packed {
        logic            capture;
        logic            clear;
        logic            prep;
        logic [OP_W-1:0] op;
        logic            load_out;
        logic            publish;
    } cmd_t;

    typedef struct packed {
        logic restart;
        logic out_busy;
    } status_t;

    function automatic logic signed [OPB_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        if (f > FACTOR_ONE)
            return OPB_W'(FACTOR_ONE);
        return OPB_W'(f);
    endfunction

    function automatic logic signed [ALT_W-1:0] median3(input logic signed [ALT_W-1:0] x,
                                                         input logic signed [ALT_W-1:0] y,
                                                         input logic signed [ALT_W-1:0] z);
        if ((x <= y && y <= z) || (z <= y && y <= x))
            return y;
        if ((y <= x && x <= z) || (z <= x && x <= y))
            return x;
        return z;
    endfunction

    function automatic logic signed [ALT_W-1:0] sat32(input logic signed [TOT_W-1:0] v);
        if (v > SAT_HI)
            return ALT_W'(SAT_HI);
        if (v < SAT_LO)
            return ALT_W'(SAT_LO);
        return ALT_W'(v);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/afc_if.sv -----
// ----------------------------------------------------------------------------
// afc_if
// valid/ready channels carrying sample words and result words
// ----------------------------------------------------------------------------
`default_nettype none

interface afc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] raw_altitude;
    logic signed [15:0] temperature;
    logic signed [31:0] vertical_accel;
    logic        [15:0] time_step;
    logic               restart;

    modport source (output valid, raw_altitude, temperature, vertical_accel, time_step,
                    restart, input ready);
    modport sink (input valid, raw_altitude, temperature, vertical_accel, time_step,
                  restart, output ready);
endinterface

interface afc_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] published_altitude;
    logic               changed;
    logic               processed;

    modport source (output valid, published_altitude, changed, processed, input ready);
    modport sink (input valid, published_altitude, changed, processed, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/afc_regs.sv -----
// ----------------------------------------------------------------------------
// afc_regs
// apb register file holding the filter configuration
// ----------------------------------------------------------------------------
`default_nettype none

module afc_regs
    import afc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [REG_W-1:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign index  = paddr[APB_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fast_smoothing        <= FACTOR_W'(52429);
            cfg_reg.slow_smoothing        <= FACTOR_W'(60293);
            cfg_reg.dead_band             <= BAND_W'(3277);
            cfg_reg.drift_gain            <= GAIN_W'(5243);
            cfg_reg.reference_temperature <= '0;
            cfg_reg.blend_factor          <= '0;
            cfg_reg.accel_smoothing       <= FACTOR_W'(3277);
            cfg_reg.reference_valid       <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_FAST_SMOOTHING:  cfg_reg.fast_smoothing <= pwdata[FACTOR_W-1:0];
                REG_SLOW_SMOOTHING:  cfg_reg.slow_smoothing <= pwdata[FACTOR_W-1:0];
                REG_DEAD_BAND:       cfg_reg.dead_band <= pwdata[BAND_W-1:0];
                REG_DRIFT_GAIN:      cfg_reg.drift_gain <= pwdata[GAIN_W-1:0];
                REG_REFERENCE_TEMP:  cfg_reg.reference_temperature <= pwdata[TEMP_W-1:0];
                REG_BLEND_FACTOR:    cfg_reg.blend_factor <= pwdata[FACTOR_W-1:0];
                REG_ACCEL_SMOOTHING: cfg_reg.accel_smoothing <= pwdata[FACTOR_W-1:0];
                REG_REFERENCE_VALID: cfg_reg.reference_valid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_FAST_SMOOTHING:  prdata = 32'(cfg_reg.fast_smoothing);
            REG_SLOW_SMOOTHING:  prdata = 32'(cfg_reg.slow_smoothing);
            REG_DEAD_BAND:       prdata = 32'(cfg_reg.dead_band);
            REG_DRIFT_GAIN:      prdata = 32'(cfg_reg.drift_gain);
            REG_REFERENCE_TEMP:  prdata = 32'(cfg_reg.reference_temperature);
            REG_BLEND_FACTOR:    prdata = 32'(cfg_reg.blend_factor);
            REG_ACCEL_SMOOTHING: prdata = 32'(cfg_reg.accel_smoothing);
            REG_REFERENCE_VALID: prdata = 32'(cfg_reg.reference_valid);
            default:             prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/afc_ctrl.sv -----
// ----------------------------------------------------------------------------
// afc_ctrl
// sequencer issuing the per-word operations to the shared datapath
// ----------------------------------------------------------------------------
`default_nettype none

module afc_ctrl
    import afc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    ref_valid,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [OP_W-1:0]   step_op;

    // issue slots: three-stage pipe, dependent ops spaced so each reads its operand after the earlier op has written it
    always_comb
    begin
        unique case (step_reg)
            4'd0:    step_op = OP_FAST;
            4'd1:    step_op = OP_DRIFT;
            4'd2:    step_op = OP_VEL;
            4'd3:    step_op = OP_SLOW;
            4'd5:    step_op = OP_INERT;
            4'd6:    step_op = OP_BARO;
            4'd8:    step_op = OP_SMOOTH;
            4'd11:   step_op = OP_FUSED;
            default: step_op = OP_NONE;
        endcase
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.capture  = (state_reg == S_IDLE) && in_valid;
    assign cmd.clear    = (state_reg == S_CLEAR) && status.restart;
    assign cmd.prep     = (state_reg == S_PREP);
    assign cmd.op       = (state_reg == S_RUN) ? step_op : OP_NONE;
    assign cmd.load_out = (state_reg == S_DONE) && !status.out_busy;
    assign cmd.publish  = cmd.load_out && ref_valid;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                state_next = ref_valid ? S_PREP : S_DONE;
            end
            S_PREP:
            begin
                state_next = S_RUN;
                step_next  = '0;
            end
            S_RUN:
            begin
                if (step_reg == LAST_STEP)
                    state_next = S_DONE;
                else
                    step_next = step_reg + 1'b1;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/afc_datapath.sv -----
// ----------------------------------------------------------------------------
// afc_datapath
// filter state, shared multiply-round-saturate pipe and result register
// ----------------------------------------------------------------------------
`default_nettype none

module afc_datapath
    import afc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire cfg_t                     cfg,
    input  wire logic signed [ALT_W-1:0]  raw_altitude,
    input  wire logic signed [TEMP_W-1:0] temperature,
    input  wire logic signed [ALT_W-1:0]  vertical_accel,
    input  wire logic        [DT_W-1:0]   time_step,
    input  wire logic                     restart,
    input  wire logic                     out_ready,
    output status_t                       status,
    output logic                          out_valid,
    output logic signed [ALT_W-1:0]       published_altitude,
    output logic                          changed,
    output logic                          processed
);

    // captured word
    logic signed [ALT_W-1:0]  raw_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [ALT_W-1:0]  accel_reg;
    logic        [DT_W-1:0]   dt_reg;
    logic                     restart_reg;

    // filter state
    logic signed [ALT_W-1:0] prev_reg;
    logic signed [ALT_W-1:0] older_reg;
    logic signed [ALT_W-1:0] fast_reg;
    logic signed [ALT_W-1:0] slow_reg;
    logic signed [ALT_W-1:0] pub_reg;
    logic                    seeded_reg;
    logic signed [ALT_W-1:0] vel_reg;
    logic signed [ALT_W-1:0] inert_reg;
    logic signed [ALT_W-1:0] smooth_reg;

    // per-word working values
    logic signed [ALT_W-1:0] med_reg;
    logic signed [SUM_W-1:0] drift_reg;
    logic signed [ALT_W-1:0] baro_reg;
    logic signed [ALT_W-1:0] fused_reg;

    // pipe
    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [ALT_W-1:0]  base;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ALT_W-1:0]  base_reg;
    logic        [OP_W-1:0]   op1_reg;
    logic signed [PRE_W-1:0]  pre;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  sum_reg;
    logic        [OP_W-1:0]   op2_reg;
    logic signed [ALT_W-1:0]  addend;
    logic signed [TOT_W-1:0]  total;
    logic signed [ALT_W-1:0]  result;

    logic signed [ALT_W-1:0] med;
    logic signed [OPA_W-1:0] pub_diff;
    logic signed [OPA_W-1:0] band;
    logic                    exceed;
    logic                    out_valid_reg;
    logic signed [ALT_W-1:0] out_alt_reg;
    logic                    out_changed_reg;
    logic                    out_processed_reg;

    assign med = median3(raw_reg, prev_reg, older_reg);

    assign pub_diff = OPA_W'(fused_reg) - OPA_W'(pub_reg);
    assign band     = $signed(OPA_W'(cfg.dead_band));
    assign exceed   = (pub_diff > band) || (pub_diff < -band);

    assign status.restart  = restart_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid          = out_valid_reg;
    assign published_altitude = out_alt_reg;
    assign changed            = out_changed_reg;
    assign processed          = out_processed_reg;

    // operand selection
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        base = '0;
        unique case (cmd.op)
            OP_FAST:
            begin
                opa  = OPA_W'(fast_reg) - OPA_W'(med_reg);
                opb  = clamp_factor(cfg.fast_smoothing);
                base = med_reg;
            end
            OP_SLOW:
            begin
                opa  = OPA_W'(slow_reg) - OPA_W'(fast_reg);
                opb  = clamp_factor(cfg.slow_smoothing);
                base = fast_reg;
            end
            OP_DRIFT:
            begin
                opa = OPA_W'(temp_reg) - OPA_W'(cfg.reference_temperature);
                opb = cfg.drift_gain;
            end
            OP_VEL:
            begin
                opa = OPA_W'(accel_reg) - GRAVITY;
                opb = OPB_W'(dt_reg);
            end
            OP_INERT:
            begin
                opa = OPA_W'(vel_reg);
                opb = OPB_W'(dt_reg);
            end
            OP_SMOOTH:
            begin
                opa  = OPA_W'(smooth_reg) - OPA_W'(inert_reg);
                opb  = clamp_factor(cfg.accel_smoothing);
                base = inert_reg;
            end
            OP_FUSED:
            begin
                opa  = OPA_W'(smooth_reg) - OPA_W'(baro_reg);
                opb  = clamp_factor(cfg.blend_factor);
                base = baro_reg;
            end
            default: ;
        endcase
    end

    // rounding stage
    always_comb
    begin
        pre = '0;
        sum = '0;
        unique case (op1_reg)
            OP_NONE: ;
            OP_DRIFT:
            begin
                pre = PRE_W'(prod_reg) + DRIFT_HALF;
                sum = SUM_W'(pre >>> DRIFT_SHIFT);
            end
            OP_BARO:
            begin
                sum = -drift_reg;
            end
            default:
            begin
                pre = PRE_W'(prod_reg) + (PRE_W'(base_reg) <<< FACTOR_BITS) + ROUND_HALF;
                sum = SUM_W'(pre >>> FACTOR_BITS);
            end
        endcase
    end

    // accumulate and saturate stage
    always_comb
    begin
        unique case (op2_reg)
            OP_VEL:   addend = vel_reg;
            OP_INERT: addend = inert_reg;
            OP_BARO:  addend = slow_reg;
            default:  addend = '0;
        endcase
    end

    assign total  = TOT_W'(sum_reg) + TOT_W'(addend);
    assign result = sat32(total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= OP_NONE;
            op2_reg <= OP_NONE;
        end
        else
        begin
            op1_reg <= cmd.op;
            op2_reg <= op1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        base_reg <= base;
        sum_reg  <= sum;
        if (cmd.capture)
        begin
            raw_reg     <= raw_altitude;
            temp_reg    <= temperature;
            accel_reg   <= vertical_accel;
            dt_reg      <= time_step;
            restart_reg <= restart;
        end
        if (cmd.prep)
            med_reg <= med;
        unique case (op2_reg)
            OP_DRIFT: drift_reg <= sum_reg;
            OP_BARO:  baro_reg <= result;
            OP_FUSED: fused_reg <= result;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            older_reg  <= '0;
            fast_reg   <= '0;
            slow_reg   <= '0;
            pub_reg    <= '0;
            seeded_reg <= 1'b0;
            vel_reg    <= '0;
            inert_reg  <= '0;
            smooth_reg <= '0;
        end
        else if (cmd.clear)
        begin
            prev_reg   <= '0;
            older_reg  <= '0;
            fast_reg   <= '0;
            slow_reg   <= '0;
            pub_reg    <= '0;
            seeded_reg <= 1'b0;
            vel_reg    <= '0;
            inert_reg  <= '0;
            smooth_reg <= '0;
        end
        else if (cmd.prep)
        begin
            prev_reg  <= raw_reg;
            older_reg <= prev_reg;
            if (!seeded_reg)
            begin
                fast_reg   <= med;
                slow_reg   <= med;
                pub_reg    <= med;
                inert_reg  <= med;
                seeded_reg <= 1'b1;
            end
        end
        else
        begin
            unique case (op2_reg)
                OP_FAST:   fast_reg <= result;
                OP_SLOW:   slow_reg <= result;
                OP_VEL:    vel_reg <= result;
                OP_INERT:  inert_reg <= result;
                OP_SMOOTH: smooth_reg <= result;
                default: ;
            endcase
            if (cmd.publish && exceed)
                pub_reg <= fused_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_alt_reg       <= (cmd.publish && exceed) ? fused_reg : pub_reg;
            out_changed_reg   <= cmd.publish && exceed;
            out_processed_reg <= cmd.publish;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/altitude_filter_chain.sv -----
// ----------------------------------------------------------------------------
// altitude_filter_chain
// median-of-three, cascaded averages, drift correction and inertial blend
// ----------------------------------------------------------------------------
// sequence: an accepted word runs its eight operations through the shared three-stage
//   multiply-round-saturate pipe; with the reference invalid it skips them
// words: the next word is accepted only once the result register has been loaded,
//   which waits while the previous result is still held
// reset: configuration returns to its defaults and all filter state to zero
// ----------------------------------------------------------------------------
`default_nettype none

module altitude_filter_chain
    import afc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    afc_sample_if.sink                 samples,
    afc_result_if.source               results,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign samples.ready = in_ready;

    afc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .ref_valid (cfg.reference_valid),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    afc_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg                (cfg),
        .raw_altitude       (samples.raw_altitude),
        .temperature        (samples.temperature),
        .vertical_accel     (samples.vertical_accel),
        .time_step          (samples.time_step),
        .restart            (samples.restart),
        .out_ready          (results.ready),
        .status             (status),
        .out_valid          (results.valid),
        .published_altitude (results.published_altitude),
        .changed            (results.changed),
        .processed          (results.processed)
    );

    a_ignored_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.processed |-> !results.changed)
        else $error("ignored word reports a change");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_busy)
        else $error("result register loaded while still held");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("second word accepted while busy");

    a_ops_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op != OP_NONE |-> !samples.ready)
        else $error("operation issued while idle");

endmodule

`default_nettype wire
